[rtl/core/ksil_pkg.sv]
package ksil_pkg;

  localparam int unsigned HASH_BITS = 16;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned DATA_W    = 17;
  localparam int unsigned MAX_KMER  = 32;
  localparam int unsigned KIDX_W    = $clog2(MAX_KMER);
  localparam int unsigned KLEN_W    = 6;
  localparam int unsigned HASH_W    = 64;

  localparam logic [HASH_BITS-1:0] HASH_MOD = {HASH_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_BUCKET = 2'd0,
    OP_POS    = 2'd1,
    OP_REF    = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic {
    CFG_KMER_LEN = 1'b0,
    CFG_REF_LEN  = 1'b1
  } cfg_idx_t;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_FOLD = 10'b0000000010,
    ST_KEY  = 10'b0000000100,
    ST_RD0  = 10'b0000001000,
    ST_RD1  = 10'b0000010000,
    ST_RD2  = 10'b0000100000,
    ST_PRD  = 10'b0001000000,
    ST_PCHK = 10'b0010000000,
    ST_RCMP = 10'b0100000000,
    ST_DONE = 10'b1000000000
  } state_t;

  // 2-bit base code, plus flag for anything that is not a base
  function automatic logic [2:0] base_code(input logic [7:0] c);
    logic [2:0] r;
    unique case (c)
      8'h41, 8'h61: r = 3'd0;
      8'h43, 8'h63: r = 3'd1;
      8'h47, 8'h67: r = 3'd2;
      8'h54, 8'h74: r = 3'd3;
      default:      r = 3'd4;
    endcase
    return r;
  endfunction

  // upper case letters to lower case
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
    return r;
  endfunction

endpackage

[rtl/core/kmer_seed_index_lookup.sv]
// a load word is written when accepted; a query word completing a k-mer runs
// the fold, key and bucket reads, then per listed position a position read and a
// compare of up to kmer_length bytes, one per cycle from the text memory
// throughput: one word per cycle for loads and partial query words while idle
// reset: synchronous active-low rst_n clears control, the hash and the byte counter;
// kmer_length returns to 32, reference_length to 0; memories are not cleared
module kmer_seed_index_lookup (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_address,
  input  logic [16:0] in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_hash_key,
  output logic [16:0] out_predicted_count,
  output logic [16:0] out_actual_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  ksil_pkg::state_t state_r, state_nxt;

  logic [ksil_pkg::KLEN_W-1:0]    kmer_len_r;
  logic [ksil_pkg::DATA_W-1:0]    ref_len_r;
  logic [ksil_pkg::KLEN_W-1:0]    cnt_r, cnt_nxt;
  logic [ksil_pkg::HASH_W-1:0]    hash_r, hash_nxt;
  logic [ksil_pkg::KLEN_W-1:0]    len_r, len_nxt;
  logic [17:0]                    sum_r, sum_nxt;
  logic [ksil_pkg::HASH_BITS-1:0] key_r, key_nxt;
  logic [ksil_pkg::DATA_W-1:0]    start_r, start_nxt;
  logic [ksil_pkg::DATA_W-1:0]    stop_r, stop_nxt;
  logic [ksil_pkg::DATA_W-1:0]    idx_r, idx_nxt;
  logic [ksil_pkg::ADDR_W-1:0]    pos_r, pos_nxt;
  logic [ksil_pkg::KIDX_W-1:0]    j_r, j_nxt;
  logic [ksil_pkg::DATA_W-1:0]    actual_r, actual_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [15:0]                    out_key_r, out_key_nxt;
  logic [16:0]                    out_pred_r, out_pred_nxt;
  logic [16:0]                    out_act_r, out_act_nxt;

  logic [7:0] kbuf [ksil_pkg::MAX_KMER];

  logic                         in_acc;
  logic                         q_acc;
  logic [ksil_pkg::KLEN_W-1:0]  len_eff;
  logic [ksil_pkg::KLEN_W:0]    cnt_inc;
  logic [2:0]                   code;
  logic [ksil_pkg::DATA_W-1:0]  ref_lim;
  logic [16:0]                  fold_t;
  logic [16:0]                  fold_m;
  logic [17:0]                  idx_inc;
  logic [17:0]                  win_end;
  logic                         out_free;

  logic                         bkt_re, pos_re, ref_re;
  logic [ksil_pkg::ADDR_W-1:0]  bkt_ra, pos_ra, ref_ra;
  logic [ksil_pkg::DATA_W-1:0]  bkt_q;
  logic [ksil_pkg::ADDR_W-1:0]  pos_q;
  logic [7:0]                   ref_q;

  assign in_ready  = (state_r == ksil_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid & in_ready;
  assign q_acc     = in_acc & (ksil_pkg::op_t'(in_operation) == ksil_pkg::OP_QUERY);
  assign out_free  = ~out_valid_r | out_ready;

  // effective k-mer length, clamped to 1..MAX_KMER
  always_comb begin
    if (kmer_len_r == '0) begin
      len_eff = ksil_pkg::KLEN_W'(1);
    end else if (kmer_len_r > ksil_pkg::KLEN_W'(ksil_pkg::MAX_KMER)) begin
      len_eff = ksil_pkg::KLEN_W'(ksil_pkg::MAX_KMER);
    end else begin
      len_eff = kmer_len_r;
    end
  end

  assign ref_lim = (ref_len_r > 17'd65536) ? 17'd65536 : ref_len_r;
  assign cnt_inc = {1'b0, cnt_r} + 7'd1;
  assign code    = ksil_pkg::base_code(in_data[7:0]);

  // end-around fold of the four-chunk sum, then one correction
  assign fold_t = {1'b0, sum_r[15:0]} + {15'd0, sum_r[17:16]};
  assign fold_m = (fold_t >= {1'b0, ksil_pkg::HASH_MOD}) ?
                  fold_t - {1'b0, ksil_pkg::HASH_MOD} : fold_t;

  assign idx_inc = {1'b0, idx_r} + 18'd1;
  assign win_end = {2'b00, pos_q} + {12'd0, len_r};

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= ksil_pkg::KLEN_W'(ksil_pkg::MAX_KMER);
      ref_len_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ksil_pkg::cfg_idx_t'(cfg_index))
        ksil_pkg::CFG_KMER_LEN: kmer_len_r <= cfg_data[ksil_pkg::KLEN_W-1:0];
        ksil_pkg::CFG_REF_LEN:  ref_len_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // k-mer byte buffer
  always_ff @(posedge clk) begin
    if (q_acc && !cnt_r[ksil_pkg::KLEN_W-1]) begin
      kbuf[cnt_r[ksil_pkg::KIDX_W-1:0]] <= in_data[7:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    hash_nxt      = hash_r;
    len_nxt       = len_r;
    sum_nxt       = sum_r;
    key_nxt       = key_r;
    start_nxt     = start_r;
    stop_nxt      = stop_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    j_nxt         = j_r;
    actual_nxt    = actual_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_key_nxt   = out_key_r;
    out_pred_nxt  = out_pred_r;
    out_act_nxt   = out_act_r;
    bkt_re        = 1'b0;
    pos_re        = 1'b0;
    ref_re        = 1'b0;
    bkt_ra        = key_r;
    pos_ra        = idx_r[15:0];
    ref_ra        = pos_q;
    unique case (state_r)
      ksil_pkg::ST_IDLE: begin
        if (q_acc) begin
          hash_nxt = {hash_r[61:0], 2'b00} + {61'd0, code};
          if (cnt_inc >= {1'b0, len_eff}) begin
            cnt_nxt   = '0;
            len_nxt   = len_eff;
            state_nxt = ksil_pkg::ST_FOLD;
          end else begin
            cnt_nxt = cnt_inc[ksil_pkg::KLEN_W-1:0];
          end
        end
      end
      ksil_pkg::ST_FOLD: begin
        sum_nxt   = {2'b00, hash_r[15:0]} + {2'b00, hash_r[31:16]}
                  + {2'b00, hash_r[47:32]} + {2'b00, hash_r[63:48]};
        hash_nxt  = '0;
        state_nxt = ksil_pkg::ST_KEY;
      end
      ksil_pkg::ST_KEY: begin
        key_nxt   = fold_m[15:0];
        state_nxt = ksil_pkg::ST_RD0;
      end
      ksil_pkg::ST_RD0: begin
        bkt_re    = 1'b1;
        bkt_ra    = key_r;
        state_nxt = ksil_pkg::ST_RD1;
      end
      ksil_pkg::ST_RD1: begin
        start_nxt = bkt_q;
        bkt_re    = 1'b1;
        bkt_ra    = key_r + 16'd1;
        state_nxt = ksil_pkg::ST_RD2;
      end
      ksil_pkg::ST_RD2: begin
        stop_nxt   = bkt_q;
        idx_nxt    = start_r;
        actual_nxt = '0;
        state_nxt  = (bkt_q > start_r) ? ksil_pkg::ST_PRD : ksil_pkg::ST_DONE;
      end
      ksil_pkg::ST_PRD: begin
        pos_re    = 1'b1;
        pos_ra    = idx_r[15:0];
        state_nxt = ksil_pkg::ST_PCHK;
      end
      ksil_pkg::ST_PCHK: begin
        pos_nxt = pos_q;
        if (win_end <= {1'b0, ref_lim}) begin
          ref_re    = 1'b1;
          ref_ra    = pos_q;
          j_nxt     = '0;
          state_nxt = ksil_pkg::ST_RCMP;
        end else begin
          idx_nxt   = idx_inc[16:0];
          state_nxt = (idx_inc < {1'b0, stop_r}) ? ksil_pkg::ST_PRD : ksil_pkg::ST_DONE;
        end
      end
      ksil_pkg::ST_RCMP: begin
        if (ksil_pkg::fold_case(ref_q) != ksil_pkg::fold_case(kbuf[j_r])) begin
          idx_nxt   = idx_inc[16:0];
          state_nxt = (idx_inc < {1'b0, stop_r}) ? ksil_pkg::ST_PRD : ksil_pkg::ST_DONE;
        end else if ({1'b0, j_r} == len_r - 6'd1) begin
          actual_nxt = actual_r + 17'd1;
          idx_nxt    = idx_inc[16:0];
          state_nxt  = (idx_inc < {1'b0, stop_r}) ? ksil_pkg::ST_PRD : ksil_pkg::ST_DONE;
        end else begin
          j_nxt  = j_r + 5'd1;
          ref_re = 1'b1;
          ref_ra = pos_r + {11'd0, j_r} + 16'd1;
        end
      end
      ksil_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = key_r;
          out_pred_nxt  = (stop_r > start_r) ? stop_r - start_r : 17'd0;
          out_act_nxt   = actual_r;
          state_nxt     = ksil_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ksil_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ksil_pkg::ST_IDLE;
      cnt_r       <= '0;
      hash_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    sum_r      <= sum_nxt;
    key_r      <= key_nxt;
    start_r    <= start_nxt;
    stop_r     <= stop_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    j_r        <= j_nxt;
    actual_r   <= actual_nxt;
    out_key_r  <= out_key_nxt;
    out_pred_r <= out_pred_nxt;
    out_act_r  <= out_act_nxt;
  end

  // table memories
  ksil_ram #(.WIDTH(ksil_pkg::DATA_W), .ADDR_W(ksil_pkg::ADDR_W)) u_bkt (
    .clk   (clk),
    .we    (in_acc && (ksil_pkg::op_t'(in_operation) == ksil_pkg::OP_BUCKET)),
    .waddr (in_address),
    .wdata (in_data),
    .re    (bkt_re),
    .raddr (bkt_ra),
    .rdata (bkt_q)
  );

  ksil_ram #(.WIDTH(ksil_pkg::ADDR_W), .ADDR_W(ksil_pkg::ADDR_W)) u_pos (
    .clk   (clk),
    .we    (in_acc && (ksil_pkg::op_t'(in_operation) == ksil_pkg::OP_POS)),
    .waddr (in_address),
    .wdata (in_data[15:0]),
    .re    (pos_re),
    .raddr (pos_ra),
    .rdata (pos_q)
  );

  ksil_ram #(.WIDTH(8), .ADDR_W(ksil_pkg::ADDR_W)) u_ref (
    .clk   (clk),
    .we    (in_acc && (ksil_pkg::op_t'(in_operation) == ksil_pkg::OP_REF)),
    .waddr (in_address),
    .wdata (in_data[7:0]),
    .re    (ref_re),
    .raddr (ref_ra),
    .rdata (ref_q)
  );

  assign out_valid           = out_valid_r;
  assign out_hash_key        = out_key_r;
  assign out_predicted_count = out_pred_r;
  assign out_actual_count    = out_act_r;

endmodule

[rtl/core/ksil_ram.sv]
module ksil_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
